/* sv/gajp_pkg.sv */
// Shared types and constants for the gimbal axis jog PID controller.
`timescale 1ns / 1ps
`default_nettype none
package gajp_pkg;

	// Field widths
	localparam int CMD_W   = 16;
	localparam int ANGLE_W = 13;
	localparam int DRIVE_W = 16;
	localparam int GAIN_W  = 24;
	localparam int ILIM_W  = 15;
	localparam int SENS_W  = 16;
	localparam int ERR_W   = 14;
	localparam int DIFF_W  = 15;
	localparam int ISUM_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int FRAC_W  = 16;

	// Shared multiplier: unsigned 24-bit gains go in zero-extended as signed 25 bits,
	// error, error delta and jog command go in sign-extended to 17 bits.
	localparam int MUL_A_W = GAIN_W + 1;
	localparam int MUL_B_W = CMD_W + 1;
	localparam int ACC_W   = MUL_A_W + MUL_B_W;

	localparam int OUTPUT_LIMIT_DEF = 30000;

	// Register reset values
	localparam logic [ANGLE_W-1:0] LOWER_RST  = 13'd5200;
	localparam logic [ANGLE_W-1:0] UPPER_RST  = 13'd7000;
	localparam logic [SENS_W-1:0]  SENS_RST   = 16'd39322;
	localparam logic [ANGLE_W-1:0] CENTER_RST = 13'd6100;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ILIM     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SENS     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_JOG_MUL,
		ST_JOG_SET,
		ST_ERR,
		ST_P_MUL,
		ST_I_MUL,
		ST_I_SUM,
		ST_D_ADD,
		ST_TOT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage
`default_nettype wire

/* sv/gajp_channels.sv */
// Handshake channel interfaces for tick words in and drive words out.
`timescale 1ns / 1ps
`default_nettype none
interface gajp_tick_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [gajp_pkg::CMD_W-1:0]    jog_command;
	logic        [gajp_pkg::ANGLE_W-1:0]  measured_angle;
	logic                                 recenter;

	modport source(output valid, jog_command, measured_angle, recenter, input ready);
	modport sink(input valid, jog_command, measured_angle, recenter, output ready);
endinterface

interface gajp_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [gajp_pkg::DRIVE_W-1:0]  drive;
	logic        [gajp_pkg::ANGLE_W-1:0]  setpoint_now;

	modport source(output valid, drive, setpoint_now, input ready);
	modport sink(input valid, drive, setpoint_now, output ready);
endinterface
`default_nettype wire

/* sv/gajp_mul.sv */
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module gajp_mul (
	input  wire logic                                   clk,
	input  wire gajp_pkg::mul_req_t                     req,
	output      logic signed [gajp_pkg::ACC_W-1:0]      prod_q
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

endmodule
`default_nettype wire

/* sv/gimbal_axis_jog_pid.sv */
// Top level: gimbal axis jog setpoint and PID position loop.
//
// Usage:
//   tick   (sink)  : one word per control tick: jog_command, measured_angle, recenter.
//   result (source): one word per tick: drive (clamped, truncated toward zero) and
//                    setpoint_now (setpoint used for that tick).
//   cfg_we/cfg_index/cfg_data: register writes, only while the block is idle.
// Timing:
//   One shared 25x17 multiplier walks the sequence jog scale, P, I, D; a new
//   tick is taken only once the previous one has reached the output register,
//   since tick.ready rises together with result.valid.
//   A finished word sits in the output register while the next tick is accepted
//   and computed; if the receiver still stalls, the sequencer waits in its last
//   step until the output register frees.
// Reset:
//   arst_n clears the sequencer, the output valid, the integral and the previous
//   error, loads register defaults and puts the setpoint at the center angle.
//   No clearing pass; ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module gimbal_axis_jog_pid #(
	parameter int OUTPUT_LIMIT = gajp_pkg::OUTPUT_LIMIT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	gajp_tick_if.sink                                tick,
	gajp_result_if.source                            result,
	input  wire logic                                cfg_we,
	input  wire logic [gajp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [gajp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int ACC_W = gajp_pkg::ACC_W;
	localparam int FRAC_W = gajp_pkg::FRAC_W;
	localparam logic signed [ACC_W-1:0] OUT_LIM_Q = ACC_W'(OUTPUT_LIMIT) <<< FRAC_W;
	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'((1 << FRAC_W) - 1);
	localparam logic signed [gajp_pkg::DRIVE_W:0] DRIVE_LIM =
		(gajp_pkg::DRIVE_W + 1)'(OUTPUT_LIMIT);

	// config registers
	logic [gajp_pkg::GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [gajp_pkg::ILIM_W-1:0]  ilim_q;
	logic [gajp_pkg::ANGLE_W-1:0] lower_q, upper_q, center_q;
	logic [gajp_pkg::SENS_W-1:0]  sens_q;

	// loop state
	gajp_pkg::state_t state_q, state_d;
	logic [gajp_pkg::ANGLE_W-1:0]        setpoint_q;
	logic signed [gajp_pkg::ISUM_W-1:0]  integral_q;
	logic signed [gajp_pkg::ERR_W-1:0]   prev_err_q;

	// per-item working registers
	logic signed [gajp_pkg::CMD_W-1:0]   cmd_q;
	logic [gajp_pkg::ANGLE_W-1:0]        meas_q;
	logic                                rec_q;
	logic signed [gajp_pkg::ERR_W-1:0]   err_q;
	logic signed [gajp_pkg::DIFF_W-1:0]  diff_q;
	logic signed [ACC_W-1:0]             acc_q;

	// output register
	logic                                out_valid_q;
	logic signed [gajp_pkg::DRIVE_W-1:0] drive_q;
	logic [gajp_pkg::ANGLE_W-1:0]        setp_out_q;

	gajp_pkg::mul_req_t      mul_req;
	logic signed [ACC_W-1:0] prod_q;

	logic tick_acc, out_load;

	assign tick.ready    = (state_q == gajp_pkg::ST_IDLE);
	assign tick_acc      = tick.valid && tick.ready;
	assign out_load      = (state_q == gajp_pkg::ST_OUT) && (!out_valid_q || result.ready);
	assign result.valid  = out_valid_q;
	assign result.drive  = drive_q;
	assign result.setpoint_now = setp_out_q;

	gajp_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	// Jog setpoint: inc = trunc toward zero of cmd*sens/2^16, clamp meas+inc to limits; recenter loads center
	logic signed [ACC_W-1:0] inc_full;
	logic signed [16:0]      inc;
	logic signed [17:0]      s_sum, lo_s, hi_s;
	logic [gajp_pkg::ANGLE_W-1:0] setp_next;

	always_comb begin
		inc_full  = (prod_q + (prod_q[ACC_W-1] ? ROUND_BIAS : '0)) >>> FRAC_W;
		inc       = inc_full[16:0];
		s_sum     = $signed({5'b0, meas_q}) + {inc[16], inc};
		lo_s      = $signed({5'b0, lower_q});
		hi_s      = $signed({5'b0, upper_q});
		setp_next = setpoint_q;
		if (rec_q) begin
			setp_next = center_q;
		end else if (inc != '0) begin
			if (s_sum <= hi_s && s_sum >= lo_s) begin
				setp_next = s_sum[gajp_pkg::ANGLE_W-1:0];
			end else if (s_sum > hi_s) begin
				setp_next = upper_q;
			end else begin
				setp_next = lower_q;
			end
		end
	end

	// Error and error delta
	logic signed [gajp_pkg::ERR_W-1:0]  err_now;
	logic signed [gajp_pkg::DIFF_W-1:0] diff_now;

	always_comb begin
		err_now  = $signed({1'b0, setpoint_q}) - $signed({1'b0, meas_q});
		diff_now = {err_now[gajp_pkg::ERR_W-1], err_now}
			- {prev_err_q[gajp_pkg::ERR_W-1], prev_err_q};
	end

	// Integral update with symmetric clamp
	logic signed [ACC_W:0]              isum_raw, ilim_ext, ilim_neg;
	logic signed [gajp_pkg::ISUM_W-1:0] isum_next;

	always_comb begin
		isum_raw = {{(ACC_W + 1 - gajp_pkg::ISUM_W){integral_q[gajp_pkg::ISUM_W-1]}}, integral_q}
			+ {prod_q[ACC_W-1], prod_q};
		ilim_ext = $signed({{(ACC_W + 1 - gajp_pkg::ILIM_W - FRAC_W){1'b0}}, ilim_q,
			{FRAC_W{1'b0}}});
		ilim_neg = -ilim_ext;
		if (isum_raw > ilim_ext) begin
			isum_next = ilim_ext[gajp_pkg::ISUM_W-1:0];
		end else if (isum_raw < ilim_neg) begin
			isum_next = ilim_neg[gajp_pkg::ISUM_W-1:0];
		end else begin
			isum_next = isum_raw[gajp_pkg::ISUM_W-1:0];
		end
	end

	// Output clamp and truncation toward zero
	logic signed [ACC_W-1:0]             tot_clamp, tot_trunc;
	logic signed [gajp_pkg::DRIVE_W-1:0] drive_next;

	always_comb begin
		if (acc_q > OUT_LIM_Q) begin
			tot_clamp = OUT_LIM_Q;
		end else if (acc_q < -OUT_LIM_Q) begin
			tot_clamp = -OUT_LIM_Q;
		end else begin
			tot_clamp = acc_q;
		end
		tot_trunc  = (tot_clamp + (tot_clamp[ACC_W-1] ? ROUND_BIAS : '0)) >>> FRAC_W;
		drive_next = tot_trunc[gajp_pkg::DRIVE_W-1:0];
	end

	// Sequencer: next state and multiplier operand select
	always_comb begin
		state_d   = state_q;
		mul_req.en = 1'b0;
		mul_req.a  = '0;
		mul_req.b  = '0;
		case (state_q)
			gajp_pkg::ST_IDLE: begin
				if (tick_acc) begin
					state_d = gajp_pkg::ST_JOG_MUL;
				end
			end
			gajp_pkg::ST_JOG_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed({9'b0, sens_q});
				mul_req.b  = {cmd_q[gajp_pkg::CMD_W-1], cmd_q};
				state_d    = gajp_pkg::ST_JOG_SET;
			end
			gajp_pkg::ST_JOG_SET: begin
				state_d = gajp_pkg::ST_ERR;
			end
			gajp_pkg::ST_ERR: begin
				state_d = gajp_pkg::ST_P_MUL;
			end
			gajp_pkg::ST_P_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed({1'b0, gain_p_q});
				mul_req.b  = {{3{err_q[gajp_pkg::ERR_W-1]}}, err_q};
				state_d    = gajp_pkg::ST_I_MUL;
			end
			gajp_pkg::ST_I_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed({1'b0, gain_i_q});
				mul_req.b  = {{3{err_q[gajp_pkg::ERR_W-1]}}, err_q};
				state_d    = gajp_pkg::ST_I_SUM;
			end
			gajp_pkg::ST_I_SUM: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed({1'b0, gain_d_q});
				mul_req.b  = {{2{diff_q[gajp_pkg::DIFF_W-1]}}, diff_q};
				state_d    = gajp_pkg::ST_D_ADD;
			end
			gajp_pkg::ST_D_ADD: begin
				state_d = gajp_pkg::ST_TOT;
			end
			gajp_pkg::ST_TOT: begin
				state_d = gajp_pkg::ST_OUT;
			end
			gajp_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = gajp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gajp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gajp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			ilim_q   <= '0;
			lower_q  <= gajp_pkg::LOWER_RST;
			upper_q  <= gajp_pkg::UPPER_RST;
			sens_q   <= gajp_pkg::SENS_RST;
			center_q <= gajp_pkg::CENTER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gajp_pkg::REG_GAIN_P: gain_p_q <= cfg_data;
				gajp_pkg::REG_GAIN_I: gain_i_q <= cfg_data;
				gajp_pkg::REG_GAIN_D: gain_d_q <= cfg_data;
				gajp_pkg::REG_ILIM:   ilim_q   <= cfg_data[gajp_pkg::ILIM_W-1:0];
				gajp_pkg::REG_LOWER:  lower_q  <= cfg_data[gajp_pkg::ANGLE_W-1:0];
				gajp_pkg::REG_UPPER:  upper_q  <= cfg_data[gajp_pkg::ANGLE_W-1:0];
				gajp_pkg::REG_SENS:   sens_q   <= cfg_data[gajp_pkg::SENS_W-1:0];
				gajp_pkg::REG_CENTER: center_q <= cfg_data[gajp_pkg::ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= gajp_pkg::CENTER_RST;
			integral_q <= '0;
			prev_err_q <= '0;
		end else begin
			if (state_q == gajp_pkg::ST_JOG_SET) begin
				setpoint_q <= setp_next;
			end
			if (state_q == gajp_pkg::ST_ERR) begin
				prev_err_q <= err_now;
			end
			if (state_q == gajp_pkg::ST_I_SUM) begin
				integral_q <= isum_next;
			end
		end
	end

	// Working registers (no reset needed)
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			cmd_q  <= tick.jog_command;
			meas_q <= tick.measured_angle;
			rec_q  <= tick.recenter;
		end
		if (state_q == gajp_pkg::ST_ERR) begin
			err_q  <= err_now;
			diff_q <= diff_now;
		end
		case (state_q)
			gajp_pkg::ST_I_MUL: acc_q <= prod_q;
			gajp_pkg::ST_D_ADD: acc_q <= acc_q
				+ {{(ACC_W - gajp_pkg::ISUM_W){integral_q[gajp_pkg::ISUM_W-1]}}, integral_q};
			gajp_pkg::ST_TOT:   acc_q <= acc_q + prod_q;
			default: ;
		endcase
		if (out_load) begin
			drive_q    <= drive_next;
			setp_out_q <= setpoint_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Drive never leaves the output clamp
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (drive_q <= DRIVE_LIM && drive_q >= -DRIVE_LIM))
		else $error("drive outside output limit");

	// Integral stays inside its clamp right after it is updated
	a_integral_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gajp_pkg::ST_D_ADD) |->
		($signed({{(ACC_W + 1 - gajp_pkg::ISUM_W){integral_q[gajp_pkg::ISUM_W-1]}},
			integral_q}) <= ilim_ext
		&& $signed({{(ACC_W + 1 - gajp_pkg::ISUM_W){integral_q[gajp_pkg::ISUM_W-1]}},
			integral_q}) >= ilim_neg))
		else $error("integral outside its limit");

	// A new result word is only loaded from the last sequencer step
	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gajp_pkg::ST_IDLE && $past(state_q) != gajp_pkg::ST_IDLE) |->
		(out_valid_q && $past(state_q) == gajp_pkg::ST_OUT))
		else $error("sequencer returned idle without loading a result");

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the gimbal axis jog PID controller: tick words in, drive words out.
`timescale 1ns / 1ps
module testbench;

	localparam int DRIVE_LIMIT  = gajp_pkg::OUTPUT_LIMIT_DEF;
	localparam int RUN_LIMIT    = 500000;	// cycles, limit for the timeout watchdog
	localparam int HOLD_CYCLES  = 600;	// long receiver hold-off to back the block up
	localparam int DRAIN_CYCLES = 30;	// extra wait before the final check for missing words
	localparam int PHASES       = 10;
	localparam int PHASE_TICKS  = 155;

	typedef struct packed {
		logic signed [gajp_pkg::CMD_W-1:0] jog_command;
		logic [gajp_pkg::ANGLE_W-1:0]      measured_angle;
		logic                              recenter;
	} tick_word_t;

	typedef struct packed {
		logic signed [gajp_pkg::DRIVE_W-1:0] drive;
		logic [gajp_pkg::ANGLE_W-1:0]        setpoint_now;
	} drive_word_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [gajp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [gajp_pkg::CFG_DATA_W-1:0] cfg_data;

	gajp_tick_if   tick_ch();
	gajp_result_if result_ch();

	gimbal_axis_jog_pid #(.OUTPUT_LIMIT(DRIVE_LIMIT)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Shadow copy of the block: registers and loop state
	// ---------------------------------------------------------------
	logic [gajp_pkg::GAIN_W-1:0]  kp, ki, kd;
	logic [gajp_pkg::ILIM_W-1:0]  integ_clamp;
	logic [gajp_pkg::ANGLE_W-1:0] angle_lo, angle_hi, angle_center;
	logic [gajp_pkg::SENS_W-1:0]  jog_scale;
	logic [gajp_pkg::ANGLE_W-1:0] track_setpoint;
	int                 integ_acc;	// Q15.16, output units
	int                 last_error;

	tick_word_t  pending_ticks[$];
	drive_word_t drive_expected[$];
	int          ticks_queued   = 0;
	int          ticks_accepted = 0;
	int          mismatch_count = 0;
	int          cycle_count    = 0;

	// driver / receiver control
	bit         tick_took      = 1'b0;	// tick word accepted at the last rising edge
	bit         sender_no_gaps = 1'b0;
	int         burst_left     = 0;
	int         gap_left       = 0;
	bit         hold_pending   = 1'b0;
	int         hold_left      = 0;
	logic [15:0] stall_mask    = '0;
	logic [3:0]  stall_pos     = '0;

	function automatic longint q16_toward_zero(longint v);
		return (v < 0) ? -((-v) >>> 16) : (v >>> 16);
	endfunction

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Advance the shadow loop by one tick and return the word the block should emit.
	function automatic drive_word_t compute_drive(tick_word_t w);
		longint      jog_step, target, err, isum, total;
		drive_word_t r;
		if (w.recenter) begin
			track_setpoint = angle_center;
		end else begin
			jog_step = q16_toward_zero(longint'($signed(w.jog_command)) * longint'(jog_scale));
			// zero increment leaves the setpoint alone
			if (jog_step != 0) begin
				target = longint'(w.measured_angle) + jog_step;
				// tested in this order even when the limits are crossed
				if (target <= longint'(angle_hi) && target >= longint'(angle_lo))
					track_setpoint = target[gajp_pkg::ANGLE_W-1:0];
				else if (target > longint'(angle_hi))
					track_setpoint = angle_hi;
				else
					track_setpoint = angle_lo;
			end
		end
		err = longint'(track_setpoint) - longint'(w.measured_angle);
		isum = clamp_mag(longint'(integ_acc) + longint'(ki) * err,
			longint'(integ_clamp) <<< gajp_pkg::FRAC_W);
		integ_acc = int'(isum);
		total = longint'(kp) * err + isum + longint'(kd) * (err - longint'(last_error));
		last_error = int'(err);
		total = clamp_mag(total, longint'(DRIVE_LIMIT) <<< gajp_pkg::FRAC_W);
		r.drive = gajp_pkg::DRIVE_W'(q16_toward_zero(total));
		r.setpoint_now = track_setpoint;
		return r;
	endfunction

	task automatic note_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------
	// Tick driver: bursts with random gaps, fed from pending_ticks
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		tick_word_t w;
		logic       offer;
		if (arst_n) begin
			offer = tick_ch.valid && !tick_took;	// hold the word until taken
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ticks.size() > 0) begin
					w = pending_ticks.pop_front();
					tick_ch.jog_command    <= w.jog_command;
					tick_ch.measured_angle <= w.measured_angle;
					tick_ch.recenter       <= w.recenter;
					offer = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						if (sender_no_gaps || $urandom_range(0, 3) == 0)
							gap_left = 0;
						else
							gap_left = $urandom_range(1, 14);
					end
				end
			end
			tick_ch.valid <= offer;
		end
	end

	// ---------------------------------------------------------------
	// Result receiver: random 16-bit stall masks, plus one long hold-off
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		logic take;
		if (arst_n) begin
			if (hold_pending) begin
				hold_left = HOLD_CYCLES;
				hold_pending = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else begin
				if (stall_pos == 0) begin
					case ($urandom_range(0, 3))
						0: stall_mask = '0;
						1: stall_mask = 16'($urandom()) & 16'($urandom());
						default: stall_mask = 16'($urandom());
					endcase
					stall_mask[$urandom_range(0, 15)] = 1'b0;	// never a full stall
				end
				take = !stall_mask[stall_pos];
				stall_pos = stall_pos + 4'd1;
			end
			result_ch.ready <= take;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: predict on tick acceptance, check on result acceptance
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		drive_word_t want;
		cycle_count++;
		tick_took = 1'b0;
		if (arst_n && tick_ch.valid && tick_ch.ready) begin
			drive_expected.push_back(compute_drive(tick_word_t'{tick_ch.jog_command,
				tick_ch.measured_angle, tick_ch.recenter}));
			ticks_accepted++;
			tick_took = 1'b1;
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (drive_expected.size() == 0) begin
				note_mismatch($sformatf("unexpected word drive=%0d setpoint=%0d",
					result_ch.drive, result_ch.setpoint_now));
			end else begin
				want = drive_expected.pop_front();
				if (result_ch.drive !== want.drive)
					note_mismatch($sformatf("drive got %0d want %0d",
						result_ch.drive, want.drive));
				if (result_ch.setpoint_now !== want.setpoint_now)
					note_mismatch($sformatf("setpoint_now got %0d want %0d",
						result_ch.setpoint_now, want.setpoint_now));
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic queue_tick(logic signed [gajp_pkg::CMD_W-1:0] jog,
		logic [gajp_pkg::ANGLE_W-1:0] meas, logic rec);
		pending_ticks.push_back(tick_word_t'{jog, meas, rec});
		ticks_queued++;
	endtask

	// Block is idle once every queued tick is in and every word is out.
	task automatic wait_idle();
		while (ticks_accepted != ticks_queued || drive_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One write per falling edge; end_writes drops the enable afterwards.
	task automatic load_reg(logic [gajp_pkg::CFG_IDX_W-1:0] idx,
		logic [gajp_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			gajp_pkg::REG_GAIN_P: kp = val[gajp_pkg::GAIN_W-1:0];
			gajp_pkg::REG_GAIN_I: ki = val[gajp_pkg::GAIN_W-1:0];
			gajp_pkg::REG_GAIN_D: kd = val[gajp_pkg::GAIN_W-1:0];
			gajp_pkg::REG_ILIM:   integ_clamp = val[gajp_pkg::ILIM_W-1:0];
			gajp_pkg::REG_LOWER:  angle_lo = val[gajp_pkg::ANGLE_W-1:0];
			gajp_pkg::REG_UPPER:  angle_hi = val[gajp_pkg::ANGLE_W-1:0];
			gajp_pkg::REG_SENS:   jog_scale = val[gajp_pkg::SENS_W-1:0];
			gajp_pkg::REG_CENTER: angle_center = val[gajp_pkg::ANGLE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [gajp_pkg::CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 24'hFFFFFF;
			2, 3: return gajp_pkg::CFG_DATA_W'($urandom_range(0, 24'h03FFFF));	// up to ~4.0
			default: return gajp_pkg::CFG_DATA_W'($urandom());
		endcase
	endfunction

	// Timeout watchdog
	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int                                i, n;
		logic [gajp_pkg::ANGLE_W-1:0]      a, b;
		logic signed [gajp_pkg::CMD_W-1:0] jog;
		logic [gajp_pkg::ANGLE_W-1:0]      meas;

		tick_ch.valid          = 1'b0;
		tick_ch.jog_command    = '0;
		tick_ch.measured_angle = '0;
		tick_ch.recenter       = 1'b0;
		result_ch.ready        = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = gajp_pkg::REG_GAIN_P;
		cfg_data               = '0;
		arst_n                 = 1'b0;

		// shadow state at reset
		kp = '0;
		ki = '0;
		kd = '0;
		integ_clamp = '0;
		angle_lo = gajp_pkg::LOWER_RST;
		angle_hi = gajp_pkg::UPPER_RST;
		jog_scale = gajp_pkg::SENS_RST;
		angle_center = gajp_pkg::CENTER_RST;
		track_setpoint = gajp_pkg::CENTER_RST;
		integ_acc = 0;
		last_error = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed: default limits and scale, modest gains ---
		load_reg(gajp_pkg::REG_GAIN_P, 24'h010000);
		load_reg(gajp_pkg::REG_GAIN_I, 24'h000800);
		load_reg(gajp_pkg::REG_GAIN_D, 24'h008000);
		load_reg(gajp_pkg::REG_ILIM, 24'd1000);
		end_writes();
		queue_tick(16'sd0, 13'd6000, 1'b0);	// no jog: setpoint holds at center
		queue_tick(16'sd1, 13'd6100, 1'b0);	// increment truncates to zero
		queue_tick(-16'sd1, 13'd6100, 1'b0);	// same, negative side
		queue_tick(16'sh7FFF, 13'd8191, 1'b0);	// overshoots upper limit
		queue_tick(16'sh8000, 13'd0, 1'b0);	// undershoots lower limit
		queue_tick(16'sd100, 13'd6500, 1'b0);	// lands inside the window
		queue_tick(16'sh8000, 13'd8191, 1'b1);	// recenter ignores the jog
		wait_idle();

		// --- directed: gains, angle limits and scale at their extremes ---
		load_reg(gajp_pkg::REG_GAIN_P, 24'hFFFFFF);
		load_reg(gajp_pkg::REG_GAIN_I, 24'hFFFFFF);
		load_reg(gajp_pkg::REG_GAIN_D, 24'hFFFFFF);
		load_reg(gajp_pkg::REG_ILIM, 24'd30000);
		load_reg(gajp_pkg::REG_LOWER, 24'd0);
		load_reg(gajp_pkg::REG_UPPER, 24'd8191);
		load_reg(gajp_pkg::REG_SENS, 24'd65535);
		end_writes();
		queue_tick(16'sd0, 13'd0, 1'b1);	// drive saturates positive
		queue_tick(16'sh7FFF, 13'd0, 1'b0);	// setpoint pinned at 8191
		queue_tick(16'sh8000, 13'd8191, 1'b0);	// setpoint pinned at 0
		queue_tick(16'sd5, 13'd4000, 1'b0);
		wait_idle();
		// center write must not move the live setpoint
		load_reg(gajp_pkg::REG_CENTER, 24'd0);
		end_writes();
		queue_tick(16'sd0, 13'd4004, 1'b0);
		queue_tick(16'sd0, 13'd8191, 1'b1);	// now recenter to 0, drive saturates negative
		wait_idle();

		// --- directed: crossed angle limits ---
		load_reg(gajp_pkg::REG_GAIN_P, 24'h000400);
		load_reg(gajp_pkg::REG_GAIN_I, 24'd0);
		load_reg(gajp_pkg::REG_GAIN_D, 24'd0);
		load_reg(gajp_pkg::REG_LOWER, 24'd7000);
		load_reg(gajp_pkg::REG_UPPER, 24'd5200);
		load_reg(gajp_pkg::REG_SENS, 24'(gajp_pkg::SENS_RST));
		load_reg(gajp_pkg::REG_CENTER, 24'(gajp_pkg::CENTER_RST));
		end_writes();
		queue_tick(16'sd1000, 13'd6000, 1'b0);
		queue_tick(-16'sd1000, 13'd6000, 1'b0);
		queue_tick(-16'sd3000, 13'd6000, 1'b0);	// below both: falls to lower
		queue_tick(16'sd20, 13'd6100, 1'b0);
		wait_idle();

		// --- directed: integral saturation ---
		load_reg(gajp_pkg::REG_GAIN_P, 24'd0);
		load_reg(gajp_pkg::REG_GAIN_I, 24'hFFFFFF);
		load_reg(gajp_pkg::REG_ILIM, 24'd5);
		load_reg(gajp_pkg::REG_LOWER, 24'd0);
		load_reg(gajp_pkg::REG_UPPER, 24'd8191);
		end_writes();
		queue_tick(16'sd0, 13'd100, 1'b1);
		queue_tick(16'sd0, 13'd100, 1'b1);
		queue_tick(16'sd0, 13'd8000, 1'b1);	// swings to the negative clamp
		wait_idle();

		// --- random phases ---
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			sender_no_gaps = 1'b0;
			if (phase == 0) begin
				load_reg(gajp_pkg::REG_GAIN_P, 24'hFFFFFF);
				load_reg(gajp_pkg::REG_GAIN_I, 24'hFFFFFF);
				load_reg(gajp_pkg::REG_GAIN_D, 24'hFFFFFF);
				load_reg(gajp_pkg::REG_ILIM, 24'd30000);
				load_reg(gajp_pkg::REG_LOWER, 24'd0);
				load_reg(gajp_pkg::REG_UPPER, 24'd8191);
				load_reg(gajp_pkg::REG_SENS, 24'd65535);
				load_reg(gajp_pkg::REG_CENTER, 24'd8191);
			end else if (phase == 1) begin
				load_reg(gajp_pkg::REG_GAIN_P, 24'd0);
				load_reg(gajp_pkg::REG_GAIN_I, 24'd0);
				load_reg(gajp_pkg::REG_GAIN_D, 24'd0);
				load_reg(gajp_pkg::REG_ILIM, 24'd0);
				load_reg(gajp_pkg::REG_LOWER, 24'd0);
				load_reg(gajp_pkg::REG_UPPER, 24'd0);
				load_reg(gajp_pkg::REG_SENS, 24'd0);
				load_reg(gajp_pkg::REG_CENTER, 24'd0);
			end else begin
				load_reg(gajp_pkg::REG_GAIN_P, pick_gain());
				load_reg(gajp_pkg::REG_GAIN_I, pick_gain());
				load_reg(gajp_pkg::REG_GAIN_D, pick_gain());
				case ($urandom_range(0, 3))
					0: load_reg(gajp_pkg::REG_ILIM, 24'd0);
					1: load_reg(gajp_pkg::REG_ILIM, 24'd30000);
					2: load_reg(gajp_pkg::REG_ILIM, 24'($urandom_range(0, 300)));
					default: load_reg(gajp_pkg::REG_ILIM, 24'($urandom_range(0, 30000)));
				endcase
				a = 13'($urandom());
				b = 13'($urandom());
				case ($urandom_range(0, 4))
					0: begin
						a = 13'd0;
						b = 13'd8191;
					end
					1: ;	// keep as drawn, possibly crossed
					default: if (a > b) begin
						a = a ^ b;
						b = a ^ b;
						a = a ^ b;
					end
				endcase
				load_reg(gajp_pkg::REG_LOWER, 24'(a));
				load_reg(gajp_pkg::REG_UPPER, 24'(b));
				case ($urandom_range(0, 3))
					0: load_reg(gajp_pkg::REG_SENS, 24'd0);
					1: load_reg(gajp_pkg::REG_SENS, 24'd65535);
					default: load_reg(gajp_pkg::REG_SENS, 24'($urandom_range(0, 65535)));
				endcase
				load_reg(gajp_pkg::REG_CENTER, 24'($urandom_range(0, 8191)));
			end
			end_writes();

			// one phase backs the block up behind a long receiver hold-off
			if (phase == 4) begin
				sender_no_gaps = 1'b1;
				hold_pending = 1'b1;
			end

			for (i = 0; i < PHASE_TICKS; i++) begin
				case ($urandom_range(0, 7))
					0: jog = 16'sd0;
					1: jog = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					2, 3, 4: jog = 16'($urandom_range(0, 400)) - 16'sd200;
					default: jog = 16'($urandom());
				endcase
				if ($urandom_range(0, 1))
					meas = 13'($urandom());
				else
					meas = 13'($urandom_range(angle_lo, angle_hi));
				queue_tick(jog, meas, $urandom_range(0, 9) == 0);
			end
		end

		// --- wind down ---
		while (ticks_accepted != ticks_queued)
			@(negedge clk);
		n = 0;
		while (drive_expected.size() != 0 && n < 2000) begin
			@(negedge clk);
			n++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (drive_expected.size() != 0)
			note_mismatch($sformatf("%0d expected words never arrived", drive_expected.size()));

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* gimbal_axis_jog_pid.f */
sv/gajp_pkg.sv
sv/gajp_channels.sv
sv/gajp_mul.sv
sv/gimbal_axis_jog_pid.sv
bench/testbench.sv
